// ----- rtl/core/lfr_pkg.sv -----
`default_nettype none

package lfr_pkg;

   // Largest pattern the window can hold, and the replacement limit
   localparam int PAT_MAX_DEF = 8;
   localparam int REPL_MAX    = 8;
   localparam int SEG_BYTES   = 8;
   localparam int SEG_W       = 8 * SEG_BYTES;
   localparam int CNT_W       = 16;
   // One replacement (or one byte), a flush of up to PAT_MAX - 1 bytes, one closing item
   localparam int MAX_RESULTS = 9;

   // Configuration register indexes
   typedef enum logic [1:0] {
      REG_PATTERN_BYTES     = 2'd0,
      REG_PATTERN_LEN       = 2'd1,
      REG_REPLACEMENT_BYTES = 2'd2,
      REG_REPLACEMENT_LEN   = 2'd3
   } csr_index_type;

   // Effective configuration seen by the window logic
   typedef struct packed {
      logic [63:0] pat_bytes;
      logic [3:0]  plen;       // clamped to 1..PAT_MAX
      logic [63:0] repl_bytes;
      logic [3:0]  rlen;       // clamped to 0..REPL_MAX
   } cfg_type;

   // Results caused by one input byte: segment A (replacement or oldest byte),
   // segment B (end-of-stream flush), then an optional closing item
   typedef struct packed {
      logic [SEG_W-1:0] a_bytes;
      logic [3:0]       a_cnt;
      logic [SEG_W-1:0] b_bytes;
      logic [3:0]       b_cnt;
      logic             close;
      logic [CNT_W-1:0] count;
   } step_type;

endpackage

`default_nettype wire

// ----- rtl/core/lfr_window.sv -----
`default_nettype none

module lfr_window #(
   parameter int PAT_MAX = lfr_pkg::PAT_MAX_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic             req_end_of_stream,
   input  wire lfr_pkg::cfg_type cfg,
   input  wire logic             cfg_clear,
   output logic                  step_valid,
   input  wire logic             step_ready,
   output lfr_pkg::step_type     step
);
   import lfr_pkg::*;

   localparam int FW = $clog2(PAT_MAX + 1);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_eos_ff;
   logic [7:0]       window_ff [PAT_MAX];
   logic [7:0]       window_in [PAT_MAX];
   logic [FW-1:0]    fill_ff, fill_in;
   logic [CNT_W-1:0] total_ff, total_in;

   logic [7:0]       w1 [PAT_MAX];
   logic [7:0]       w2 [PAT_MAX];
   logic [FW-1:0]    f1, f2;
   logic             full, hit, fire;
   logic [CNT_W-1:0] total_inc;

   // Input register stage
   assign fire        = in_valid_ff && step_ready;
   assign req_ready   = !in_valid_ff || step_ready;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;
   assign step_valid  = in_valid_ff;

   // Window update, compare and result segments
   always_comb begin
      w1 = window_ff;
      for (int i = 0; i < PAT_MAX; i++) begin
         if (fill_ff == FW'(i)) begin
            w1[i] = in_byte_ff;
         end
      end
      f1 = (fill_ff < FW'(PAT_MAX)) ? FW'(fill_ff + 1'b1) : fill_ff;
      full = 4'(f1) >= cfg.plen;

      hit = 1'b1;
      for (int i = 0; i < PAT_MAX; i++) begin
         if ((4'(i) < cfg.plen) && (w1[i] != cfg.pat_bytes[8*i +: 8])) begin
            hit = 1'b0;
         end
      end

      total_inc = total_ff;
      w2 = w1;
      f2 = f1;
      step.a_bytes = '0;
      step.a_cnt   = '0;
      if (full) begin
         if (hit) begin
            if (total_ff != {CNT_W{1'b1}}) begin
               total_inc = total_ff + 1'b1;
            end
            step.a_bytes = cfg.repl_bytes;
            step.a_cnt   = cfg.rlen;
            f2 = '0;
         end else begin
            step.a_bytes[7:0] = w1[0];
            step.a_cnt        = 4'd1;
            for (int i = 0; i < PAT_MAX - 1; i++) begin
               w2[i] = w1[i+1];
            end
            f2 = FW'(f1 - 1'b1);
         end
      end

      // End of stream: flush what is left, then the closing item
      step.b_bytes = '0;
      for (int i = 0; i < PAT_MAX; i++) begin
         step.b_bytes[8*i +: 8] = w2[i];
      end
      step.b_cnt = in_eos_ff ? 4'(f2) : 4'd0;
      step.close = in_eos_ff;
      step.count = total_inc;

      window_in = window_ff;
      fill_in   = fill_ff;
      total_in  = total_ff;
      if (fire) begin
         window_in = w2;
         fill_in   = in_eos_ff ? '0 : f2;
         total_in  = in_eos_ff ? '0 : total_inc;
      end
      if (cfg_clear) begin
         fill_in = '0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         fill_ff     <= '0;
         total_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         fill_ff     <= fill_in;
         total_ff    <= total_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_byte_ff <= req_data_byte;
         in_eos_ff  <= req_end_of_stream;
      end
      window_ff <= window_in;
   end

   // Pending bytes always fewer than the pattern length
   a_fill_below_plen: assert property (@(posedge clock) disable iff (reset)
      4'(fill_ff) < cfg.plen)
      else $error("window fill reached pattern length");

   // End of stream leaves an empty window and a fresh count
   a_eos_restarts: assert property (@(posedge clock) disable iff (reset)
      fire && in_eos_ff |=> fill_ff == '0 && total_ff == '0)
      else $error("stream state not cleared after end of stream");

   // Count only moves on a transfer to the emitter
   a_total_steady: assert property (@(posedge clock) disable iff (reset)
      !fire |=> total_ff == $past(total_ff))
      else $error("match count changed without a transfer");

endmodule

`default_nettype wire

// ----- rtl/core/lfr_emit.sv -----
`default_nettype none

module lfr_emit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step_valid,
   output logic                           step_ready,
   input  wire lfr_pkg::step_type         step,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_byte_valid,
   output logic                           rsp_last,
   output logic [lfr_pkg::CNT_W-1:0]      rsp_replacement_count
);
   import lfr_pkg::*;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_bv_ff, rsp_bv_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [SEG_W-1:0] a_bytes_ff, a_bytes_in;
   logic [3:0]       a_cnt_ff, a_cnt_in;
   logic [SEG_W-1:0] b_bytes_ff, b_bytes_in;
   logic [3:0]       b_cnt_ff, b_cnt_in;
   logic             close_ff, close_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [4:0]       rem;
   logic             out_load, step_fire;

   assign rem        = 5'(a_cnt_ff) + 5'(b_cnt_ff) + 5'(close_ff);
   assign out_load   = !rsp_valid_ff || rsp_ready;
   assign step_ready = (rem == 5'd0) || ((rem == 5'd1) && out_load);
   assign step_fire  = step_valid && step_ready;

   // Pop one pending result into the output register, then refill pending
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_bv_in    = rsp_bv_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;
      a_bytes_in   = a_bytes_ff;
      a_cnt_in     = a_cnt_ff;
      b_bytes_in   = b_bytes_ff;
      b_cnt_in     = b_cnt_ff;
      close_in     = close_ff;
      count_in     = count_ff;

      if (out_load) begin
         rsp_valid_in = 1'b0;
         if (rem != 5'd0) begin
            rsp_valid_in = 1'b1;
            rsp_count_in = count_ff;
            if (a_cnt_ff != 4'd0) begin
               rsp_byte_in = a_bytes_ff[7:0];
               rsp_bv_in   = 1'b1;
               rsp_last_in = 1'b0;
               a_bytes_in  = a_bytes_ff >> 8;
               a_cnt_in    = a_cnt_ff - 1'b1;
            end else if (b_cnt_ff != 4'd0) begin
               rsp_byte_in = b_bytes_ff[7:0];
               rsp_bv_in   = 1'b1;
               rsp_last_in = 1'b0;
               b_bytes_in  = b_bytes_ff >> 8;
               b_cnt_in    = b_cnt_ff - 1'b1;
            end else begin
               rsp_byte_in = 8'd0;
               rsp_bv_in   = 1'b0;
               rsp_last_in = 1'b1;
               close_in    = 1'b0;
            end
         end
      end

      if (step_fire) begin
         a_bytes_in = step.a_bytes;
         a_cnt_in   = step.a_cnt;
         b_bytes_in = step.b_bytes;
         b_cnt_in   = step.b_cnt;
         close_in   = step.close;
         count_in   = step.count;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         a_cnt_ff     <= '0;
         b_cnt_ff     <= '0;
         close_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         a_cnt_ff     <= a_cnt_in;
         b_cnt_ff     <= b_cnt_in;
         close_ff     <= close_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      rsp_byte_ff  <= rsp_byte_in;
      rsp_bv_ff    <= rsp_bv_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
      a_bytes_ff   <= a_bytes_in;
      b_bytes_ff   <= b_bytes_in;
      count_ff     <= count_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_out_byte          = rsp_byte_ff;
   assign rsp_byte_valid        = rsp_bv_ff;
   assign rsp_last              = rsp_last_ff;
   assign rsp_replacement_count = rsp_count_ff;

   // Never more results pending than one byte can cause
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rem <= 5'(MAX_RESULTS))
      else $error("too many pending results");

   // Closing item carries no stream byte
   a_last_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> !rsp_bv_ff)
      else $error("closing item marked as stream byte");

   // With nothing pending, a taken result leaves the output empty
   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready && rem == 5'd0 && !step_fire |=> !rsp_valid_ff)
      else $error("output stayed valid with nothing pending");

endmodule

`default_nettype wire

// ----- rtl/core/literal_find_and_replace_stream.sv -----
// Path: input register, then the emitter's pending registers, then the output register.
// Throughput: 1 byte per cycle while each byte causes at most one result and rsp_ready
//   stays high; a byte causing more than one result (replacement expansion, end-of-stream
//   flush) holds the input until the one-result-per-cycle output register has taken them.
// Reset: synchronous, active high; clears handshakes, window fill, match count and
//   configuration (pattern length 1, everything else 0). Window bytes are not cleared.
`default_nettype none

module literal_find_and_replace_stream #(
   parameter int PAT_MAX = lfr_pkg::PAT_MAX_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [7:0]                   req_data_byte,
   input  wire logic                         req_end_of_stream,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_byte_valid,
   output logic                              rsp_last,
   output logic [lfr_pkg::CNT_W-1:0]         rsp_replacement_count,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire lfr_pkg::csr_index_type       csr_index,
   input  wire logic [63:0]                  csr_data
);
   import lfr_pkg::*;

   logic [63:0] pat_bytes_ff, pat_bytes_in;
   logic [3:0]  pat_len_ff, pat_len_in;
   logic [63:0] repl_bytes_ff, repl_bytes_in;
   logic [3:0]  repl_len_ff, repl_len_in;
   logic        csr_fire, cfg_clear;
   cfg_type     cfg;
   logic        step_valid, step_ready;
   step_type    step;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   // Configuration register writes
   always_comb begin
      pat_bytes_in  = pat_bytes_ff;
      pat_len_in    = pat_len_ff;
      repl_bytes_in = repl_bytes_ff;
      repl_len_in   = repl_len_ff;
      cfg_clear     = 1'b0;
      if (csr_fire) begin
         case (csr_index)
            REG_PATTERN_BYTES:     pat_bytes_in = csr_data;
            REG_PATTERN_LEN: begin
               pat_len_in = csr_data[3:0];
               cfg_clear  = 1'b1;
            end
            REG_REPLACEMENT_BYTES: repl_bytes_in = csr_data;
            REG_REPLACEMENT_LEN:   repl_len_in = csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_bytes_ff  <= '0;
         pat_len_ff    <= 4'd1;
         repl_bytes_ff <= '0;
         repl_len_ff   <= '0;
      end else begin
         pat_bytes_ff  <= pat_bytes_in;
         pat_len_ff    <= pat_len_in;
         repl_bytes_ff <= repl_bytes_in;
         repl_len_ff   <= repl_len_in;
      end
   end

   // Effective lengths: zero pattern acts as one, oversize values clamp
   always_comb begin
      cfg.pat_bytes  = pat_bytes_ff;
      cfg.repl_bytes = repl_bytes_ff;
      cfg.plen       = pat_len_ff;
      if (pat_len_ff == 4'd0) begin
         cfg.plen = 4'd1;
      end else if (pat_len_ff > 4'(PAT_MAX)) begin
         cfg.plen = 4'(PAT_MAX);
      end
      cfg.rlen = (repl_len_ff > 4'(REPL_MAX)) ? 4'(REPL_MAX) : repl_len_ff;
   end

   lfr_window #(
      .PAT_MAX (PAT_MAX)
   ) u_window (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .cfg               (cfg),
      .cfg_clear         (cfg_clear),
      .step_valid        (step_valid),
      .step_ready        (step_ready),
      .step              (step)
   );

   lfr_emit u_emit (
      .clock                 (clock),
      .reset                 (reset),
      .step_valid            (step_valid),
      .step_ready            (step_ready),
      .step                  (step),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_out_byte          (rsp_out_byte),
      .rsp_byte_valid        (rsp_byte_valid),
      .rsp_last              (rsp_last),
      .rsp_replacement_count (rsp_replacement_count)
   );

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import lfr_pkg::*;

   localparam int SETTLE_CYCLES = 8;     // output register latency plus margin
   localparam int QUIET_LIMIT   = 2000;  // cycles with no transfer before giving up
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 32;
   localparam int TAIL_BYTES    = 8;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        last;
      logic [15:0] count;
   } rsp_item_type;

   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;

   // One line of the directed table: a register write or a stream byte,
   // optionally with its results typed in
   typedef struct packed {
      row_kind_type  kind;
      csr_index_type idx;
      logic [63:0]   wdata;
      logic [7:0]    data;
      logic          eos;
      logic          typed;
      logic [1:0]    n_typed;
      rsp_item_type  t0;
      rsp_item_type  t1;
   } stim_row_type;

   localparam rsp_item_type NO_RSP = '0;
   localparam int NUM_ROWS = 37;

   localparam stim_row_type DIRECTED [NUM_ROWS] = '{
      // after reset: pattern is one zero byte, empty replacement
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'hFF, 1'b0, 1'b1, 2'd1,
        '{8'hFF, 1'b1, 1'b0, 16'd0}, NO_RSP},
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b0, 1'b1, 2'd0, NO_RSP, NO_RSP},
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b1, 1'b1, 2'd1,
        '{8'h00, 1'b0, 1'b1, 16'd2}, NO_RSP},
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'hFF, 1'b1, 1'b1, 2'd2,
        '{8'hFF, 1'b1, 1'b0, 16'd0}, '{8'h00, 1'b0, 1'b1, 16'd0}},
      // "abc" -> "XY", overlapping prefix and a partial flush
      '{ROW_CSR, REG_PATTERN_BYTES, 64'h636261, 8'h00, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_CSR, REG_PATTERN_LEN, 64'd3, 8'h00, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_CSR, REG_REPLACEMENT_BYTES, 64'h5958, 8'h00, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_CSR, REG_REPLACEMENT_LEN, 64'd2, 8'h00, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h61, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h61, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h62, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h63, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h61, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h62, 1'b1, 1'b0, 2'd0, NO_RSP, NO_RSP},
      // length write while bytes are pending drops them
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h61, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h62, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_CSR, REG_PATTERN_LEN, 64'd3, 8'h00, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h63, 1'b1, 1'b0, 2'd0, NO_RSP, NO_RSP},
      // zero pattern length, replacement length above the limit: 9 results
      '{ROW_CSR, REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 2'd0,
        NO_RSP, NO_RSP},
      '{ROW_CSR, REG_PATTERN_LEN, 64'd0, 8'h00, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_CSR, REG_REPLACEMENT_BYTES, 64'h8877_6655_4433_2211, 8'h00, 1'b0, 1'b0, 2'd0,
        NO_RSP, NO_RSP},
      '{ROW_CSR, REG_REPLACEMENT_LEN, 64'd15, 8'h00, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'hFF, 1'b1, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      // pattern length above the limit acts as a full 8-byte window
      '{ROW_CSR, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_CSR, REG_PATTERN_LEN, 64'd9, 8'h00, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_CSR, REG_REPLACEMENT_BYTES, 64'hFF, 8'h00, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_CSR, REG_REPLACEMENT_LEN, 64'd1, 8'h00, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{ROW_BYTE, REG_PATTERN_BYTES, 64'h0, 8'h00, 1'b1, 1'b0, 2'd0, NO_RSP, NO_RSP}
   };

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   logic [7:0]    req_data_byte;
   logic          req_end_of_stream;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [7:0]    rsp_out_byte;
   logic          rsp_byte_valid;
   logic          rsp_last;
   logic [15:0]   rsp_replacement_count;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   logic [63:0]   csr_data;

   // Shadow configuration and window state
   logic [63:0] shadow_pat;
   logic [3:0]  shadow_plen;
   logic [63:0] shadow_repl;
   logic [3:0]  shadow_rlen;
   logic [7:0]  win [8];
   int          win_fill;
   logic [15:0] match_total;

   rsp_item_type step_out [$];     // results of the byte just transferred
   rsp_item_type pending_out [$];  // results still to come from the block
   rsp_item_type head;

   int fails = 0;
   int quiet = 0;
   int stall_left = 0;
   bit calm = 1'b0;

   literal_find_and_replace_stream dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_data_byte         (req_data_byte),
      .req_end_of_stream     (req_end_of_stream),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_out_byte          (rsp_out_byte),
      .rsp_byte_valid        (rsp_byte_valid),
      .rsp_last              (rsp_last),
      .rsp_replacement_count (rsp_replacement_count),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int eff_plen();
      if (shadow_plen == 4'd0) return 1;
      if (shadow_plen > 4'd8) return 8;
      return int'(shadow_plen);
   endfunction

   function automatic void push_result(logic [7:0] b, logic bv, logic lst);
      rsp_item_type it;
      it.out_byte   = b;
      it.byte_valid = bv;
      it.last       = lst;
      it.count      = match_total;
      step_out.push_back(it);
   endfunction

   // Find-and-replace on one byte; leaves its results in step_out
   function automatic void scan_byte(logic [7:0] d, logic e);
      int  plen;
      int  rlen;
      bit  hit;
      plen = eff_plen();
      step_out.delete();
      if (win_fill < 8) begin
         win[win_fill] = d;
         win_fill++;
      end
      if (win_fill >= plen) begin
         hit = 1'b1;
         for (int i = 0; i < plen; i++)
            if (win[i] != shadow_pat[8*i +: 8]) hit = 1'b0;
         if (hit) begin
            if (match_total != 16'hFFFF) match_total++;
            rlen = (shadow_rlen > 4'd8) ? 8 : int'(shadow_rlen);
            for (int i = 0; i < rlen; i++)
               push_result(shadow_repl[8*i +: 8], 1'b1, 1'b0);
            win_fill = 0;
         end else begin
            push_result(win[0], 1'b1, 1'b0);
            for (int i = 1; i < win_fill; i++) win[i-1] = win[i];
            win_fill--;
         end
      end
      if (e) begin
         for (int i = 0; i < win_fill; i++) push_result(win[i], 1'b1, 1'b0);
         win_fill = 0;
         push_result(8'h00, 1'b0, 1'b1);
         match_total = '0;
      end
   endfunction

   function automatic void apply_csr(csr_index_type idx, logic [63:0] value);
      case (idx)
         REG_PATTERN_BYTES: shadow_pat = value;
         REG_PATTERN_LEN: begin
            shadow_plen = value[3:0];
            win_fill = 0;
         end
         REG_REPLACEMENT_BYTES: shadow_repl = value;
         REG_REPLACEMENT_LEN: shadow_rlen = value[3:0];
         default: ;
      endcase
   endfunction

   // Mostly short idles, a few long ones
   function automatic int pick_idle();
      if ($urandom_range(0, 99) < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fails++;
      end
   endfunction

   // Hold the input until every result is out and the window logic has settled
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_out.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [63:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One byte transfer; called and returns at a falling edge
   task automatic send_byte(input logic [7:0] d, input logic e, input bit use_model);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 99) < 40) gap = pick_idle();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= d;
      req_end_of_stream <= e;
      do @(posedge clock); while (!req_ready);
      scan_byte(d, e);
      if (use_model)
         foreach (step_out[i]) pending_out.push_back(step_out[i]);
      @(negedge clock);
   endtask

   // Random configuration, then a stream that is mostly pattern hits and near misses
   task automatic run_random_phase(input int target);
      logic [63:0] pat;
      logic [7:0]  burst [$];
      int          r;
      int          sent;
      int          k;
      int          plen;
      logic        e;
      r = $urandom_range(0, 3);
      if (r == 0) pat = '1;
      else if (r == 1) pat = '0;
      else if (r == 2) pat = {$urandom, $urandom};
      else for (int i = 0; i < 8; i++) pat[8*i +: 8] = $urandom_range(0, 1) ? 8'h41 : 8'h42;
      write_reg(REG_PATTERN_BYTES, pat);
      r = $urandom_range(0, 9);
      if (r == 0) k = 0;
      else if (r == 1) k = $urandom_range(9, 15);
      else if (r == 2) k = 8;
      else if (r == 3) k = 1;
      else k = $urandom_range(1, 8);
      write_reg(REG_PATTERN_LEN, {$urandom, $urandom & 32'hFFFF_FFF0 | k});
      write_reg(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
      k = ($urandom_range(0, 9) < 2) ? $urandom_range(9, 15) : $urandom_range(0, 8);
      write_reg(REG_REPLACEMENT_LEN, {$urandom, $urandom & 32'hFFFF_FFF0 | k});
      plen = eff_plen();
      sent = 0;
      while (sent < target) begin
         burst.delete();
         r = $urandom_range(0, 9);
         if (r <= 4) begin
            for (int i = 0; i < plen; i++) burst.push_back(shadow_pat[8*i +: 8]);
         end else if (r <= 6) begin
            k = $urandom_range(0, plen - 1);
            for (int i = 0; i < k; i++) burst.push_back(shadow_pat[8*i +: 8]);
            burst.push_back(8'($urandom_range(0, 255)));
         end else if (r <= 8) begin
            k = $urandom_range(0, plen - 1);
            burst.push_back(shadow_pat[8*k +: 8]);
         end else begin
            burst.push_back(8'($urandom_range(0, 255)));
         end
         e = ($urandom_range(0, 7) == 0);
         foreach (burst[i]) send_byte(burst[i], e && (i == burst.size() - 1), 1'b1);
         sent += burst.size();
         if ($urandom_range(0, 39) == 0) wait_drained();
      end
   endtask

   // Receiver back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
         rsp_ready  <= 1'b0;
         stall_left <= pick_idle() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_out.size() == 0) begin
            $display({"%0t: unexpected result, expected none, ",
                      "actual byte %0h valid %0b last %0b count %0h"},
                     $time, rsp_out_byte, rsp_byte_valid, rsp_last, rsp_replacement_count);
            fails++;
         end else begin
            head = pending_out.pop_front();
            check_field("out_byte", head.out_byte, rsp_out_byte);
            check_field("byte_valid", head.byte_valid, rsp_byte_valid);
            check_field("last", head.last, rsp_last);
            check_field("replacement_count", head.count, rsp_replacement_count);
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            quiet <= 0;
         end else if (quiet + 1 >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
         end else begin
            quiet <= quiet + 1;
         end
      end
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_data_byte     = 8'h00;
      req_end_of_stream = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = REG_PATTERN_BYTES;
      csr_data          = 64'h0;
      shadow_pat        = 64'h0;
      shadow_plen       = 4'd1;
      shadow_repl       = 64'h0;
      shadow_rlen       = 4'd0;
      win_fill          = 0;
      match_total       = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table
      for (int i = 0; i < NUM_ROWS; i++) begin
         if (DIRECTED[i].kind == ROW_CSR) begin
            write_reg(DIRECTED[i].idx, DIRECTED[i].wdata);
         end else begin
            send_byte(DIRECTED[i].data, DIRECTED[i].eos, !DIRECTED[i].typed);
            if (DIRECTED[i].typed) begin
               if (DIRECTED[i].n_typed > 0) pending_out.push_back(DIRECTED[i].t0);
               if (DIRECTED[i].n_typed > 1) pending_out.push_back(DIRECTED[i].t1);
            end
         end
      end

      // Random phases; the third and any picked at random run without idling
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         calm = (p == 2) || ($urandom_range(0, 4) == 0);
         run_random_phase(PHASE_ITEMS);
      end

      // Back-to-back hits with an empty replacement, then hits that emit one byte
      calm = 1'b1;
      write_reg(REG_PATTERN_BYTES, 64'h5A);
      write_reg(REG_PATTERN_LEN, 64'd1);
      write_reg(REG_REPLACEMENT_LEN, 64'd0);
      for (int i = 0; i < TAIL_BYTES; i++) send_byte(8'h5A, 1'b0, 1'b1);
      calm = 1'b0;
      write_reg(REG_REPLACEMENT_LEN, 64'd1);
      for (int i = 0; i < 4; i++) send_byte(8'h5A, i == 3, 1'b1);

      // Drain and let any stray result show up
      req_valid <= 1'b0;
      while (pending_out.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fails == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
